[design/srfp_pkg.sv]
// ----------------------------------------------------------------------------
// srfp_pkg: shared types and constants of the servo reply frame parser
// Holds the transaction format between the front and back parts, the result
// record, configuration register indexes and the fixed frame layout.
// ----------------------------------------------------------------------------
package srfp_pkg;

  // Input item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_REG  = 1'b1;

  // Result kinds
  localparam logic KIND_VOLTAGE  = 1'b0;
  localparam logic KIND_POSITION = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEADER       = 2'd0;
  localparam logic [1:0] CFG_VOLTAGE_OP   = 2'd1;
  localparam logic [1:0] CFG_POSITION_OP  = 2'd2;

  // Frame layout: index 1 is the second header byte
  localparam int FRAME_LEN_POS  = 2;
  localparam int FRAME_CMD_POS  = 3;
  localparam int FRAME_ARG_POS  = 4;
  localparam int FRAME_ARG2_POS = 5;
  localparam int ENTRY_BASE     = 5;
  localparam int ENTRY_STRIDE   = 3;
  localparam int ENTRY_LIMIT    = 32;
  localparam int ID_LIMIT       = 32;
  localparam int MIN_LENGTH     = 2;
  localparam int VOLTAGE_MIN_LEN  = 4;
  localparam int POSITION_MIN_LEN = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_REG,
    CMD_STORE,
    CMD_END
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] idx;
    logic [7:0] data;
    logic [7:0] len;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  servo_id;
    logic [4:0]  slot;
    logic [15:0] reading;
  } result_t;

endpackage

[design/srfp_front.sv]
// ----------------------------------------------------------------------------
// srfp_front: header hunt and frame classification
// Tracks the header count, byte index and frame length, and turns accepted
// items into store, end-of-frame or registration transactions.
// ----------------------------------------------------------------------------
module srfp_front #(
  parameter int FRAME_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [7:0]           value,
  input  logic [7:0]           header_byte,
  input  logic                 q_full,
  output logic                 push,
  output srfp_pkg::entry_t     push_entry
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam logic [9:0] DEPTH_L = 10'(FRAME_DEPTH);

  logic          in_frame, in_frame_next;
  logic          header_half, header_half_next;
  logic [AW-1:0] byte_index, byte_index_next;
  logic [7:0]    frame_length, frame_length_next;
  logic          accept;
  logic          bad_length;
  logic          frame_done;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign bad_length = (value < 8'(srfp_pkg::MIN_LENGTH)) ||
                      ((10'(value) + 10'd2) > DEPTH_L);
  assign frame_done = (10'(byte_index) + 10'd1) == (10'(frame_length) + 10'd2);

  // Classify the item and work out the next parse state
  always_comb begin
    in_frame_next     = in_frame;
    header_half_next  = header_half;
    byte_index_next   = byte_index;
    frame_length_next = frame_length;
    push              = 1'b0;
    push_entry.cmd    = srfp_pkg::CMD_STORE;
    push_entry.idx    = 8'(byte_index);
    push_entry.data   = value;
    push_entry.len    = frame_length;
    if (accept) begin
      if (op == srfp_pkg::OP_REG) begin
        push           = 1'b1;
        push_entry.cmd = srfp_pkg::CMD_REG;
      end else if (!in_frame) begin
        if (value == header_byte) begin
          if (header_half) begin
            // second header byte is stored at index 1
            in_frame_next    = 1'b1;
            header_half_next = 1'b0;
            byte_index_next  = AW'(2);
            push             = 1'b1;
            push_entry.idx   = 8'd1;
          end else begin
            header_half_next = 1'b1;
          end
        end else begin
          header_half_next = 1'b0;
        end
      end else if (byte_index == AW'(srfp_pkg::FRAME_LEN_POS)) begin
        if (bad_length) begin
          // drop the frame and hunt again
          in_frame_next   = 1'b0;
          byte_index_next = '0;
        end else begin
          frame_length_next = value;
          byte_index_next   = AW'(3);
          push              = 1'b1;
        end
      end else begin
        push = 1'b1;
        if (frame_done) begin
          push_entry.cmd  = srfp_pkg::CMD_END;
          in_frame_next   = 1'b0;
          byte_index_next = '0;
        end else begin
          byte_index_next = byte_index + AW'(1);
        end
      end
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      header_half  <= 1'b0;
      byte_index   <= '0;
      frame_length <= 8'd2;
    end else begin
      in_frame     <= in_frame_next;
      header_half  <= header_half_next;
      byte_index   <= byte_index_next;
      frame_length <= frame_length_next;
    end
  end

endmodule

[design/srfp_queue.sv]
// ----------------------------------------------------------------------------
// srfp_queue: short transaction queue between front and back
// Lets the front keep taking bytes while the back is busy decoding.
// ----------------------------------------------------------------------------
module srfp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  srfp_pkg::entry_t push_entry,
  output logic             full,
  output logic             q_valid,
  output srfp_pkg::entry_t q_entry,
  input  logic             pop
);

  localparam int PW = $clog2(srfp_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(srfp_pkg::QUEUE_DEPTH + 1);

  srfp_pkg::entry_t slots [srfp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == CW'(srfp_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_entry = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Store transactions
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[design/srfp_back.sv]
// ----------------------------------------------------------------------------
// srfp_back: frame store, servo registration and frame decoding
// Writes frame bytes into the frame memory, keeps the ID to slot map, and at
// the end of a frame walks the stored bytes to produce results.
// ----------------------------------------------------------------------------
module srfp_back #(
  parameter int FRAME_DEPTH = 128,
  parameter int MAX_IDS     = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  srfp_pkg::entry_t q_entry,
  output logic             q_pop,
  input  logic [7:0]       voltage_opcode,
  input  logic [7:0]       position_opcode,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             kind,
  output logic [4:0]       servo_id,
  output logic [4:0]       slot,
  output logic [15:0]      reading,
  output logic             last
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int SW = $clog2(MAX_IDS);
  localparam int UW = $clog2(MAX_IDS + 1);
  localparam int IDW = $clog2(srfp_pkg::ID_LIMIT);
  localparam int EW = $clog2(srfp_pkg::ENTRY_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_CMDW,
    S_CNT,
    S_VHI,
    S_ENT,
    S_ID,
    S_LO,
    S_HI,
    S_PUSH,
    S_FIN
  } state_t;

  state_t state;

  logic [7:0]    frame_mem [FRAME_DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic                  map_valid [srfp_pkg::ID_LIMIT];
  logic [SW-1:0]         map_slot  [srfp_pkg::ID_LIMIT];
  logic [UW-1:0]         slots_used;

  logic [7:0]    len;
  logic          is_pos;
  logic [7:0]    count;
  logic [EW-1:0] ent_i;
  logic [7:0]    base;
  logic [7:0]    cur_id;
  logic [7:0]    cur_lo;

  srfp_pkg::result_t pend;
  logic              pend_valid;
  srfp_pkg::result_t cand;
  logic              cand_valid;
  srfp_pkg::result_t out_res;

  logic          out_free;
  logic          out_load;
  logic [IDW-1:0] reg_id;
  logic          reg_ok;
  logic          entry_ok;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign mem_we   = q_pop && ((q_entry.cmd == srfp_pkg::CMD_STORE) ||
                              (q_entry.cmd == srfp_pkg::CMD_END));
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && pend_valid &&
                    (((state == S_PUSH) && cand_valid) || (state == S_FIN));

  assign reg_id = q_entry.data[IDW-1:0];
  assign reg_ok = (q_entry.data != 8'd0) &&
                  (q_entry.data < 8'(srfp_pkg::ID_LIMIT)) &&
                  !map_valid[reg_id] &&
                  (slots_used < UW'(MAX_IDS));

  assign entry_ok = (8'(ent_i) < count) &&
                    (ent_i < EW'(srfp_pkg::ENTRY_LIMIT)) &&
                    ((9'(base) + 9'd1) <= 9'(len));

  assign kind     = out_res.kind;
  assign servo_id = out_res.servo_id;
  assign slot     = out_res.slot;
  assign reading  = out_res.reading;

  // Select the frame byte to fetch next
  always_comb begin
    unique case (state)
      S_CMD:   rd_addr = AW'(srfp_pkg::FRAME_CMD_POS);
      S_CMDW:  rd_addr = AW'(srfp_pkg::FRAME_ARG_POS);
      S_CNT:   rd_addr = AW'(srfp_pkg::FRAME_ARG2_POS);
      S_ENT:   rd_addr = AW'(base);
      S_ID:    rd_addr = AW'(base + 8'd1);
      S_LO:    rd_addr = AW'(base + 8'd2);
      default: rd_addr = '0;
    endcase
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[AW'(q_entry.idx)] <= q_entry.data;
    end
    rd_data <= frame_mem[rd_addr];
  end

  // Sequencer, map and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      cand_valid <= 1'b0;
      slots_used <= '0;
      for (int i = 0; i < srfp_pkg::ID_LIMIT; i++) begin
        map_valid[i] <= 1'b0;
      end
    end else begin
      // load a new result, or drop the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_entry.cmd)
              srfp_pkg::CMD_REG: begin
                if (reg_ok) begin
                  map_valid[reg_id] <= 1'b1;
                  map_slot[reg_id]  <= SW'(slots_used);
                  slots_used        <= slots_used + UW'(1);
                end
              end
              srfp_pkg::CMD_END: begin
                len   <= q_entry.len;
                state <= S_CMD;
              end
              default: begin
              end
            endcase
          end
        end
        S_CMD: begin
          state <= S_CMDW;
        end
        S_CMDW: begin
          // voltage reply wins when both opcodes match
          priority if (rd_data == voltage_opcode) begin
            is_pos <= 1'b0;
            state  <= (len >= 8'(srfp_pkg::VOLTAGE_MIN_LEN)) ? S_CNT : S_IDLE;
          end else if (rd_data == position_opcode) begin
            is_pos <= 1'b1;
            state  <= (len >= 8'(srfp_pkg::POSITION_MIN_LEN)) ? S_CNT : S_IDLE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CNT: begin
          if (is_pos) begin
            count <= rd_data;
            ent_i <= '0;
            base  <= 8'(srfp_pkg::ENTRY_BASE);
            state <= S_ENT;
          end else begin
            cur_lo <= rd_data;
            state  <= S_VHI;
          end
        end
        S_VHI: begin
          pend.kind     <= srfp_pkg::KIND_VOLTAGE;
          pend.servo_id <= 5'd0;
          pend.slot     <= 5'd0;
          pend.reading  <= {rd_data, cur_lo};
          pend_valid    <= 1'b1;
          state         <= S_FIN;
        end
        S_ENT: begin
          state <= entry_ok ? S_ID : S_FIN;
        end
        S_ID: begin
          cur_id <= rd_data;
          state  <= S_LO;
        end
        S_LO: begin
          cur_lo <= rd_data;
          state  <= S_HI;
        end
        S_HI: begin
          cand.kind     <= srfp_pkg::KIND_POSITION;
          cand.servo_id <= cur_id[4:0];
          cand.slot     <= 5'(map_slot[cur_id[IDW-1:0]]);
          cand.reading  <= {rd_data, cur_lo};
          cand_valid    <= (cur_id < 8'(srfp_pkg::ID_LIMIT)) &&
                           map_valid[cur_id[IDW-1:0]];
          state         <= S_PUSH;
        end
        S_PUSH: begin
          // hold one result back so the final one can be marked last
          if (!cand_valid) begin
            ent_i <= ent_i + EW'(1);
            base  <= base + 8'(srfp_pkg::ENTRY_STRIDE);
            state <= S_ENT;
          end else if (!pend_valid) begin
            pend       <= cand;
            pend_valid <= 1'b1;
            ent_i      <= ent_i + EW'(1);
            base       <= base + 8'(srfp_pkg::ENTRY_STRIDE);
            state      <= S_ENT;
          end else if (out_free) begin
            out_res   <= pend;
            last      <= 1'b0;
            pend      <= cand;
            ent_i     <= ent_i + EW'(1);
            base      <= base + 8'(srfp_pkg::ENTRY_STRIDE);
            state     <= S_ENT;
          end
        end
        S_FIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_res    <= pend;
            last       <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/servo_reply_frame_parser.sv]
// ----------------------------------------------------------------------------
// servo_reply_frame_parser: servo bus reply parser, top level
// Input channel (in_valid/in_stall, op, value) carries received UART bytes
// or servo IDs to register. Output channel (out_valid/out_stall) carries one
// transaction per battery-voltage reply or per registered servo entry of a
// position reply, with last set on the final one of a frame.
// A byte or registration is taken whenever the front queue has room. At the
// end of a frame the decoder walks the frame memory through its single read
// port: the pop, the command and the count, then each position entry (up to
// 32) in turn, and it waits whenever the receiver holds a result. While it
// walks, the four-entry queue fills and then in_stall rises.
// Reset clears parse state, the ID map and the queue, and restores the header
// byte to 85 and the opcodes to 15 and 21. No clearing pass is needed.
// When out_stall is high with a result valid, the result register holds and
// the decoder waits. Configuration is written through cfg_write, cfg_index
// and cfg_data; the user must write it only while idle, which the block
// itself does not enforce.
// ----------------------------------------------------------------------------
module servo_reply_frame_parser #(
  parameter int FRAME_DEPTH = 128,
  parameter int MAX_IDS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [4:0]  servo_id,
  output logic [4:0]  slot,
  output logic [15:0] reading,
  output logic        last
);

  logic [7:0] header_byte;
  logic [7:0] voltage_opcode;
  logic [7:0] position_opcode;

  logic             push;
  srfp_pkg::entry_t push_entry;
  logic             q_full;
  logic             q_valid;
  srfp_pkg::entry_t q_entry;
  logic             q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte     <= 8'd85;
      voltage_opcode  <= 8'd15;
      position_opcode <= 8'd21;
    end else if (cfg_write) begin
      unique case (cfg_index)
        srfp_pkg::CFG_HEADER:      header_byte     <= cfg_data;
        srfp_pkg::CFG_VOLTAGE_OP:  voltage_opcode  <= cfg_data;
        srfp_pkg::CFG_POSITION_OP: position_opcode <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  srfp_front #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .value       (value),
    .header_byte (header_byte),
    .q_full      (q_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  srfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (q_pop)
  );

  srfp_back #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .MAX_IDS    (MAX_IDS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop),
    .voltage_opcode  (voltage_opcode),
    .position_opcode (position_opcode),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .servo_id        (servo_id),
    .slot            (slot),
    .reading         (reading),
    .last            (last)
  );

endmodule

[tb/sv/srfp_reply_checker.sv]
// ----------------------------------------------------------------------------
// srfp_reply_checker: prediction and checking for the servo reply frame parser
// Watches the configuration port and both channels. It keeps its own copy of
// the parse state, the ID map and the registers, and predicts the results of
// each accepted input transaction. It compares every accepted result field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module srfp_reply_checker #(
  parameter int FRAME_DEPTH = 128,
  parameter int MAX_IDS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        op,
  input  logic [7:0]  value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        kind,
  input  logic [4:0]  servo_id,
  input  logic [4:0]  slot,
  input  logic [15:0] reading,
  input  logic        last,
  output int          mismatches,
  output int          outstanding,
  output int          voltage_count,
  output int          position_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    srfp_pkg::result_t fields;
    logic              last;
  } reply_t;

  // Register copies
  logic [7:0] header_cfg;
  logic [7:0] voltage_cfg;
  logic [7:0] position_cfg;

  // Parse state
  logic       in_frame;
  logic [1:0] header_hits;
  int         byte_pos;
  int         frame_len;
  logic [7:0] frame_mem [FRAME_DEPTH];
  logic [5:0] slot_of [srfp_pkg::ID_LIMIT];
  int         slots_taken;

  reply_t     expected_replies [$];
  int         errors;
  int         n_voltage;
  int         n_position;

  function automatic logic [7:0] frame_at(input int i);
    return (i < FRAME_DEPTH) ? frame_mem[i] : 8'd0;
  endfunction

  task automatic clear_state();
    header_cfg   = 8'd85;
    voltage_cfg  = 8'd15;
    position_cfg = 8'd21;
    in_frame     = 1'b0;
    header_hits  = 2'd0;
    byte_pos     = 0;
    frame_len    = 2;
    slots_taken  = 0;
    for (int i = 0; i < FRAME_DEPTH; i++) frame_mem[i] = 8'd0;
    for (int i = 0; i < srfp_pkg::ID_LIMIT; i++) slot_of[i] = 6'd0;
    expected_replies.delete();
  endtask

  // Turn a completed frame into its expected results
  task automatic decode_frame();
    reply_t     r;
    logic [7:0] cmd;
    logic [7:0] id;
    logic [5:0] s;
    int         count;
    int         base;
    int         found;
    found = 0;
    cmd = frame_at(srfp_pkg::FRAME_CMD_POS);
    if (cmd == voltage_cfg) begin
      if (frame_len >= srfp_pkg::VOLTAGE_MIN_LEN) begin
        r.fields.kind     = srfp_pkg::KIND_VOLTAGE;
        r.fields.servo_id = 5'd0;
        r.fields.slot     = 5'd0;
        r.fields.reading  = {frame_at(srfp_pkg::FRAME_ARG2_POS),
                             frame_at(srfp_pkg::FRAME_ARG_POS)};
        r.last            = 1'b0;
        expected_replies.push_back(r);
        found++;
      end
    end else if (cmd == position_cfg && frame_len >= srfp_pkg::POSITION_MIN_LEN) begin
      count = int'(frame_at(srfp_pkg::FRAME_ARG_POS));
      // walk entries that lie wholly inside the frame, capped at the entry limit
      for (int i = 0; i < count && i < srfp_pkg::ENTRY_LIMIT &&
           srfp_pkg::ENTRY_STRIDE * i + srfp_pkg::ENTRY_BASE + 1 <= frame_len; i++) begin
        base = srfp_pkg::ENTRY_BASE + srfp_pkg::ENTRY_STRIDE * i;
        id = frame_at(base);
        if (id < srfp_pkg::ID_LIMIT && slot_of[id[4:0]] != 6'd0) begin
          s = slot_of[id[4:0]] - 6'd1;
          r.fields.kind     = srfp_pkg::KIND_POSITION;
          r.fields.servo_id = id[4:0];
          r.fields.slot     = s[4:0];
          r.fields.reading  = {frame_at(base + 2), frame_at(base + 1)};
          r.last            = 1'b0;
          expected_replies.push_back(r);
          found++;
        end
      end
    end
    // flag the final result of the frame
    if (found > 0) begin
      r = expected_replies.pop_back();
      r.last = 1'b1;
      expected_replies.push_back(r);
    end
  endtask

  // Advance the predicted parser by one input transaction
  task automatic parse_item(input logic op_i, input logic [7:0] b);
    if (op_i == srfp_pkg::OP_REG) begin
      if (b >= 1 && b < srfp_pkg::ID_LIMIT && slot_of[b[4:0]] == 6'd0 &&
          slots_taken < MAX_IDS) begin
        slots_taken++;
        slot_of[b[4:0]] = 6'(slots_taken);
      end
      return;
    end
    // hunt for two header bytes in a row
    if (!in_frame) begin
      if (b == header_cfg) begin
        header_hits++;
        if (header_hits >= 2) begin
          header_hits = 2'd0;
          in_frame    = 1'b1;
          byte_pos    = 1;
        end
      end else begin
        header_hits = 2'd0;
        byte_pos    = 0;
      end
    end
    if (!in_frame) return;
    if (byte_pos < FRAME_DEPTH) frame_mem[byte_pos] = b;
    // drop the frame on a length that is too short or too long
    if (byte_pos == srfp_pkg::FRAME_LEN_POS) begin
      if (b < srfp_pkg::MIN_LENGTH || b + 2 > FRAME_DEPTH) begin
        in_frame    = 1'b0;
        header_hits = 2'd0;
        byte_pos    = 0;
        return;
      end
      frame_len = int'(b);
    end
    byte_pos++;
    if (byte_pos >= 3 && byte_pos == frame_len + 2) begin
      in_frame = 1'b0;
      byte_pos = 0;
      decode_frame();
      return;
    end
    if (byte_pos >= FRAME_DEPTH) begin
      in_frame = 1'b0;
      byte_pos = 0;
    end
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_result();
    reply_t want;
    if (expected_replies.size() == 0) begin
      $error("unexpected result: kind %0d servo_id %0d slot %0d reading %0h last %0d",
             kind, servo_id, slot, reading, last);
      errors++;
      return;
    end
    want = expected_replies.pop_front();
    if (kind !== want.fields.kind) begin
      $error("kind mismatch: expected %0d, actual %0d", want.fields.kind, kind);
      errors++;
    end
    if (servo_id !== want.fields.servo_id) begin
      $error("servo_id mismatch: expected %0d, actual %0d", want.fields.servo_id, servo_id);
      errors++;
    end
    if (slot !== want.fields.slot) begin
      $error("slot mismatch: expected %0d, actual %0d", want.fields.slot, slot);
      errors++;
    end
    if (reading !== want.fields.reading) begin
      $error("reading mismatch: expected %0h, actual %0h", want.fields.reading, reading);
      errors++;
    end
    if (last !== want.last) begin
      $error("last mismatch: expected %0d, actual %0d", want.last, last);
      errors++;
    end
    if (want.fields.kind == srfp_pkg::KIND_VOLTAGE) n_voltage++;
    else n_position++;
  endtask

  // Track register writes and both channels at each clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      errors     = 0;
      n_voltage  = 0;
      n_position = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          srfp_pkg::CFG_HEADER:      header_cfg   = cfg_data;
          srfp_pkg::CFG_VOLTAGE_OP:  voltage_cfg  = cfg_data;
          srfp_pkg::CFG_POSITION_OP: position_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_item(op, value);
      if (out_valid && !out_stall) check_result();
    end
    mismatches     <= errors;
    outstanding    <= expected_replies.size();
    voltage_count  <= n_voltage;
    position_count <= n_position;
  end

endmodule

[tb/sv/servo_reply_frame_parser_tb.sv]
// ----------------------------------------------------------------------------
// servo_reply_frame_parser_tb: regression for the servo reply frame parser
// Drives ID registrations and reply frames under several register settings
// and idling mixes, with a long receiver hold-off, and leaves prediction and
// comparison to the checker. Gives the verdict once all results are in.
// ----------------------------------------------------------------------------
module servo_reply_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_DEPTH    = 128;
  localparam int MAX_IDS        = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 400;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = srfp_pkg::CFG_HEADER;
  logic [7:0]  cfg_data  = 8'd0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        op        = srfp_pkg::OP_BYTE;
  logic [7:0]  value     = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [4:0]  servo_id;
  logic [4:0]  slot;
  logic [15:0] reading;
  logic        last;

  int mismatches;
  int pending;
  int voltage_count;
  int position_count;

  // Stimulus control
  int         items_sent = 0;
  int         idle_pct   = 0;
  int         stall_pct  = 0;
  bit         hold_req   = 1'b0;
  int         quiet_cycles = 0;
  logic [7:0] header_now   = 8'd85;
  logic [7:0] voltage_now  = 8'd15;
  logic [7:0] position_now = 8'd21;

  servo_reply_frame_parser #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .MAX_IDS    (MAX_IDS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .servo_id (servo_id),
    .slot     (slot),
    .reading  (reading),
    .last     (last)
  );

  srfp_reply_checker #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .MAX_IDS    (MAX_IDS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .servo_id      (servo_id),
    .slot          (slot),
    .reading       (reading),
    .last          (last),
    .mismatches    (mismatches),
    .outstanding   (pending),
    .voltage_count (voltage_count),
    .position_count(position_count)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        held++;
        if (held >= HOLD_CYCLES) begin
          held     = 0;
          hold_req = 1'b0;
        end
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one input transaction and hold it until accepted
  task automatic send_item(input logic o, input logic [7:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every predicted result has arrived, then let the decoder finish
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges
  task automatic apply_settings(input logic [7:0] h, input logic [7:0] v,
                                input logic [7:0] p);
    cfg_write <= 1'b1;
    cfg_index <= srfp_pkg::CFG_HEADER;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= srfp_pkg::CFG_VOLTAGE_OP;
    cfg_data  <= v;
    @(posedge clk);
    cfg_index <= srfp_pkg::CFG_POSITION_OP;
    cfg_data  <= p;
    @(posedge clk);
    cfg_write    <= 1'b0;
    header_now   = h;
    voltage_now  = v;
    position_now = p;
  endtask

  // One random chunk: noise, a registration, or a frame (mostly well formed)
  task automatic send_random_frame();
    int         pick;
    int         len;
    int         cnt;
    int         stop_at;
    bit         is_pos;
    logic [7:0] cmd;
    logic [7:0] b;
    pick   = $urandom_range(0, 99);
    is_pos = 1'b0;
    cnt    = 0;
    if (pick < 8) begin
      b = ($urandom_range(0, 2) == 0) ? header_now : 8'($urandom_range(0, 255));
      send_item(srfp_pkg::OP_BYTE, b);
      return;
    end
    if (pick < 18) begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(1, 31));
      send_item(srfp_pkg::OP_REG, b);
      return;
    end
    send_item(srfp_pkg::OP_BYTE, header_now);
    send_item(srfp_pkg::OP_BYTE, header_now);
    pick = $urandom_range(0, 99);
    // abort on a bad length
    if (pick < 6) begin
      b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1))
                                      : 8'($urandom_range(127, 255));
      send_item(srfp_pkg::OP_BYTE, b);
      return;
    end
    if (pick < 40) begin
      cmd = voltage_now;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 8) : 4;
    end else if (pick < 90) begin
      cmd    = position_now;
      is_pos = 1'b1;
      cnt    = ($urandom_range(0, 14) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 6);
      len    = srfp_pkg::ENTRY_STRIDE * cnt + 3;
      if ($urandom_range(0, 4) == 0) len = $urandom_range(2, srfp_pkg::ENTRY_STRIDE * cnt + 5);
      if (len > FRAME_DEPTH - 2) len = FRAME_DEPTH - 2;
    end else begin
      cmd = 8'($urandom_range(0, 255));
      len = $urandom_range(2, 10);
    end
    send_item(srfp_pkg::OP_BYTE, len[7:0]);
    // now and then cut the frame short
    stop_at = len + 1;
    if ($urandom_range(0, 29) == 0) stop_at = $urandom_range(2, len);
    for (int idx = srfp_pkg::FRAME_CMD_POS; idx <= stop_at; idx++) begin
      if (idx == srfp_pkg::FRAME_CMD_POS) b = cmd;
      else if (is_pos && idx == srfp_pkg::FRAME_ARG_POS) b = cnt[7:0];
      else if (is_pos && (idx - srfp_pkg::ENTRY_BASE) % srfp_pkg::ENTRY_STRIDE == 0)
        b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(32, 255))
                                        : 8'($urandom_range(0, 31));
      else b = 8'($urandom_range(0, 255));
      send_item(srfp_pkg::OP_BYTE, b);
    end
  endtask

  // Position frame for servos 1 to 8, sent while the receiver holds off
  task automatic send_held_frame();
    for (int id = 1; id <= 8; id++) send_item(srfp_pkg::OP_REG, id[7:0]);
    hold_req = 1'b1;
    send_item(srfp_pkg::OP_BYTE, header_now);
    send_item(srfp_pkg::OP_BYTE, header_now);
    send_item(srfp_pkg::OP_BYTE, 8'd27);
    send_item(srfp_pkg::OP_BYTE, position_now);
    send_item(srfp_pkg::OP_BYTE, 8'd8);
    for (int id = 1; id <= 8; id++) begin
      send_item(srfp_pkg::OP_BYTE, id[7:0]);
      send_item(srfp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      send_item(srfp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic [7:0] h, input logic [7:0] v, input logic [7:0] p,
                           input int idle, input int stall, input int count,
                           input bit with_hold);
    int target;
    drain();
    apply_settings(h, v, p);
    idle_pct  = idle;
    stall_pct = stall;
    if (with_hold) send_held_frame();
    target = items_sent + count;
    while (items_sent < target) send_random_frame();
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registration: ID zero, a new ID, the same ID again, an ID out of range
    send_item(srfp_pkg::OP_REG, 8'd0);
    send_item(srfp_pkg::OP_REG, 8'd31);
    send_item(srfp_pkg::OP_REG, 8'd31);
    send_item(srfp_pkg::OP_REG, 8'hFF);
    // Noise, then a frame with a length that is too short
    send_item(srfp_pkg::OP_BYTE, 8'h13);
    send_item(srfp_pkg::OP_BYTE, 8'h55);
    send_item(srfp_pkg::OP_BYTE, 8'h55);
    send_item(srfp_pkg::OP_BYTE, 8'h01);
    // Voltage reply
    send_item(srfp_pkg::OP_BYTE, 8'h55);
    send_item(srfp_pkg::OP_BYTE, 8'h55);
    send_item(srfp_pkg::OP_BYTE, 8'h04);
    send_item(srfp_pkg::OP_BYTE, 8'h0F);
    send_item(srfp_pkg::OP_BYTE, 8'h34);
    send_item(srfp_pkg::OP_BYTE, 8'h12);
    // Position reply: three entries claimed, two fit, one ID not mapped
    send_item(srfp_pkg::OP_BYTE, 8'h55);
    send_item(srfp_pkg::OP_BYTE, 8'h55);
    send_item(srfp_pkg::OP_BYTE, 8'h09);
    send_item(srfp_pkg::OP_BYTE, 8'h15);
    send_item(srfp_pkg::OP_BYTE, 8'h03);
    send_item(srfp_pkg::OP_BYTE, 8'h1F);
    send_item(srfp_pkg::OP_BYTE, 8'h00);
    send_item(srfp_pkg::OP_BYTE, 8'hFF);
    send_item(srfp_pkg::OP_BYTE, 8'h07);
    send_item(srfp_pkg::OP_BYTE, 8'hCD);
    send_item(srfp_pkg::OP_BYTE, 8'hAB);
    in_valid <= 1'b0;

    // Register extremes under every idling mix; equal opcodes in one phase
    run_phase(8'hFF, 8'h00, 8'hFF, 52, 0, 35, 1'b0);
    run_phase(8'h00, 8'h33, 8'h33, 0, 52, 35, 1'b0);
    run_phase(8'hA5, 8'hFF, 8'h00, 18, 18, 35, 1'b1);
    run_phase(8'h55, 8'h0F, 8'h15, 0, 0, 35, 1'b0);
    drain();

    $display("Summary: %0d input transactions over five register settings, covering ID",
             items_sent);
    $display("Summary: registration, noise, bad lengths, cut frames; %0d voltage, %0d %s",
             voltage_count, position_count, "position results");
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
